@@ hdl/ookpd_pkg.sv @@
// Shared types and constants for the OOK pulse-pair decoder.
// No dependencies; used by ookpd_window and ook_pulse_pair_decoder_top.
`timescale 1ns / 1ps

package ookpd_pkg;

  // Field widths
  localparam int unsigned COUNT_W   = 16;
  localparam int unsigned US_W      = 15;
  localparam int unsigned TOL_W     = 7;
  localparam int unsigned NOM_W     = 14;
  localparam int unsigned VALUE_W   = 2;
  localparam int unsigned INDEX_W   = 6;
  localparam int unsigned CFG_IDX_W = 4;
  localparam int unsigned CFG_DAT_W = 16;

  // Window bounds: nominal times (100 -/+ tolerance), compared against 100 * magnitude
  localparam int unsigned BOUND_W = 22;

  localparam int unsigned FRAME_BITS_DEFAULT = 64;

  // Count to microseconds: count * 16 / 3, saturated.
  // Counts at or above this value saturate.
  localparam logic [COUNT_W-1:0] COUNT_SAT = 16'd6144;
  localparam logic [US_W-1:0]    US_MAX    = 15'd32767;
  // ceil(2^17 / 3), exact for products below 2^17
  localparam logic [15:0]        RECIP3    = 16'd43691;
  localparam int unsigned        RECIP3_SH = 17;

  localparam logic [TOL_W-1:0] TOL_MAX = 7'd99;

  // Register reset values
  localparam logic [TOL_W-1:0] TOL_RESET   = 7'd50;
  localparam logic [NOM_W-1:0] SHORT_RESET = 14'd275;
  localparam logic [NOM_W-1:0] ZERO_RESET  = 14'd1225;
  localparam logic [NOM_W-1:0] START_RESET = 14'd2675;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SHORT     = 4'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ZERO      = 4'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_START     = 4'd3;

  // Decoded pair codes
  localparam logic [VALUE_W-1:0] BIT_ZERO    = 2'd0;
  localparam logic [VALUE_W-1:0] BIT_ONE     = 2'd1;
  localparam logic [VALUE_W-1:0] BIT_INVALID = 2'd2;

  typedef struct packed {
    logic [BOUND_W-1:0] lo;
    logic [BOUND_W-1:0] hi;
  } window_bounds_t;

endpackage

@@ hdl/ookpd_window.sv @@
// Tolerance window compare for one duration magnitude against one nominal.
// Depends on ookpd_pkg for widths and the bounds struct.
`timescale 1ns / 1ps

module ookpd_window (
  input  logic [ookpd_pkg::US_W-1:0]  mag_i,
  input  ookpd_pkg::window_bounds_t   bounds_i,
  output logic                        match_o
);

  logic [ookpd_pkg::BOUND_W-1:0] mag_x100;
  logic [ookpd_pkg::BOUND_W-1:0] mag_p1_x100;

  assign mag_x100    = ookpd_pkg::BOUND_W'(mag_i) * ookpd_pkg::BOUND_W'(100);
  assign mag_p1_x100 = mag_x100 + ookpd_pkg::BOUND_W'(100);

  // lo < mag  <=>  n*(100-t) < 100*mag;  mag < hi  <=>  100*(mag+1) <= n*(100+t)
  assign match_o = (bounds_i.lo < mag_x100) && (mag_p1_x100 <= bounds_i.hi);

endmodule

@@ hdl/ook_pulse_pair_decoder_top.sv @@
// Top level of the OOK pulse-pair decoder: edge-count input, decoded bit output.
// Depends on ookpd_pkg and ookpd_window.
`timescale 1ns / 1ps

//  channel  | direction | handshake              | payload
//  ---------+-----------+------------------------+------------------------------------------
//  s_axis   | in        | s_axis_tvalid/tready   | tdata[15:0] elapsed_count
//  m_axis   | out       | m_axis_tvalid/tready   | tdata[1:0] bit_value, [7:2] bit_index;
//           |           |                        | tlast frame_last
//  cfg      | in        | cfg_valid/cfg_ready    | cfg_index, cfg_data (ready always high)
//
//  One edge event per cycle unless a held result stalls the input. An event is converted
//  to microseconds on its way into the input register; from there it is compared and
//  updates the decoder state, and a result lands in the output register.
//  Reset clears the state and loads the register defaults; no clearing pass.
//  A held result stalls the input only when the waiting event would itself produce one.

module ook_pulse_pair_decoder_top #(
  parameter int unsigned FRAME_BITS = ookpd_pkg::FRAME_BITS_DEFAULT
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,

  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  input  logic [15:0]                       s_axis_tdata_i,   // [15:0] elapsed_count

  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  output logic [7:0]                        m_axis_tdata_o,   // [1:0] bit_value, [7:2] bit_index
  output logic                              m_axis_tlast_o,   // frame_last

  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [ookpd_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [ookpd_pkg::CFG_DAT_W-1:0]   cfg_data_i
);

  localparam int unsigned CAP_W = $clog2(2 * FRAME_BITS + 1);
  localparam logic [CAP_W-1:0] CAP_FULL   = CAP_W'(2 * FRAME_BITS);
  localparam logic [CAP_W-1:0] FRAME_CNT  = CAP_W'(FRAME_BITS);
  localparam int unsigned      PROD_W     = (ookpd_pkg::COUNT_W + 1) + 16;

  // Configuration registers
  logic [ookpd_pkg::TOL_W-1:0] tol_q;
  logic [ookpd_pkg::NOM_W-1:0] short_q, zero_q, start_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q   <= ookpd_pkg::TOL_RESET;
      short_q <= ookpd_pkg::SHORT_RESET;
      zero_q  <= ookpd_pkg::ZERO_RESET;
      start_q <= ookpd_pkg::START_RESET;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        ookpd_pkg::CFG_TOLERANCE: tol_q   <= cfg_data_i[ookpd_pkg::TOL_W-1:0];
        ookpd_pkg::CFG_SHORT:     short_q <= cfg_data_i[ookpd_pkg::NOM_W-1:0];
        ookpd_pkg::CFG_ZERO:      zero_q  <= cfg_data_i[ookpd_pkg::NOM_W-1:0];
        ookpd_pkg::CFG_START:     start_q <= cfg_data_i[ookpd_pkg::NOM_W-1:0];
        default: ;
      endcase
    end
  end

  // Window bounds, refreshed every cycle from the registers
  logic [ookpd_pkg::TOL_W-1:0] tol_clamped;
  logic [7:0]                  pct_lo, pct_hi;
  ookpd_pkg::window_bounds_t   short_bnd_q, zero_bnd_q, start_bnd_q;

  assign tol_clamped = (tol_q > ookpd_pkg::TOL_MAX) ? ookpd_pkg::TOL_MAX : tol_q;
  assign pct_lo      = 8'd100 - {1'b0, tol_clamped};
  assign pct_hi      = 8'd100 + {1'b0, tol_clamped};

  always_ff @(posedge clk_i) begin
    short_bnd_q.lo <= ookpd_pkg::BOUND_W'(short_q) * ookpd_pkg::BOUND_W'(pct_lo);
    short_bnd_q.hi <= ookpd_pkg::BOUND_W'(short_q) * ookpd_pkg::BOUND_W'(pct_hi);
    zero_bnd_q.lo  <= ookpd_pkg::BOUND_W'(zero_q)  * ookpd_pkg::BOUND_W'(pct_lo);
    zero_bnd_q.hi  <= ookpd_pkg::BOUND_W'(zero_q)  * ookpd_pkg::BOUND_W'(pct_hi);
    start_bnd_q.lo <= ookpd_pkg::BOUND_W'(start_q) * ookpd_pkg::BOUND_W'(pct_lo);
    start_bnd_q.hi <= ookpd_pkg::BOUND_W'(start_q) * ookpd_pkg::BOUND_W'(pct_hi);
  end

  // Count to microseconds on the way into the input register
  logic [ookpd_pkg::COUNT_W:0]  count_x16;
  logic [PROD_W-1:0]            recip_prod;
  logic [ookpd_pkg::US_W-1:0]   us_in;

  assign count_x16  = {s_axis_tdata_i[12:0], 4'b0000};
  assign recip_prod = PROD_W'(count_x16) * PROD_W'(ookpd_pkg::RECIP3);
  assign us_in      = (s_axis_tdata_i >= ookpd_pkg::COUNT_SAT) ? ookpd_pkg::US_MAX
                    : recip_prod[ookpd_pkg::RECIP3_SH +: ookpd_pkg::US_W];

  logic                       in_valid_q;
  logic [ookpd_pkg::US_W-1:0] us_q;

  // Decoder state: durations kept as magnitude plus a low flag
  logic                       phase_q;
  logic [ookpd_pkg::US_W-1:0] prev_mag_q, held_mag_q;
  logic                       prev_low_q, held_low_q;
  logic [CAP_W-1:0]           cap_q;

  logic out_valid_q;
  logic out_valid_d;
  logic [ookpd_pkg::VALUE_W-1:0] out_value_q;
  logic [ookpd_pkg::INDEX_W-1:0] out_index_q;
  logic                          out_last_q;

  logic searching, pair_end, gives_result, advance;

  assign searching    = (cap_q == '0);
  assign pair_end     = cap_q[0];
  assign gives_result = !searching && pair_end;
  assign advance      = in_valid_q && (!gives_result || !out_valid_q || m_axis_tready_i);

  assign s_axis_tready_o = !in_valid_q || advance;

  // Hold the result until taken; load a new one when a low half completes a pair
  assign out_valid_d = (advance && gives_result) || (out_valid_q && !m_axis_tready_i);

  // Window compares
  logic [ookpd_pkg::US_W-1:0] ref_mag;
  logic                       ref_low;
  logic ref_short_win, cur_short_win, cur_zero_win, cur_start_win;

  assign ref_mag = searching ? prev_mag_q : held_mag_q;
  assign ref_low = searching ? prev_low_q : held_low_q;

  ookpd_window u_ref_short (.mag_i(ref_mag), .bounds_i(short_bnd_q), .match_o(ref_short_win));
  ookpd_window u_cur_short (.mag_i(us_q),    .bounds_i(short_bnd_q), .match_o(cur_short_win));
  ookpd_window u_cur_zero  (.mag_i(us_q),    .bounds_i(zero_bnd_q),  .match_o(cur_zero_win));
  ookpd_window u_cur_start (.mag_i(us_q),    .bounds_i(start_bnd_q), .match_o(cur_start_win));

  logic ref_high_short, cur_low_short, cur_low_zero, cur_low_start;

  assign ref_high_short = !ref_low && ref_short_win;
  assign cur_low_short  = phase_q && cur_short_win;
  assign cur_low_zero   = phase_q && cur_zero_win;
  assign cur_low_start  = phase_q && cur_start_win;

  logic [ookpd_pkg::VALUE_W-1:0] value_d;
  logic [CAP_W-1:0]              half_d;
  logic [ookpd_pkg::INDEX_W-1:0] index_d;

  always_comb begin
    value_d = ookpd_pkg::BIT_INVALID;
    if (ref_high_short) begin
      if (cur_low_short) begin
        value_d = ookpd_pkg::BIT_ONE;
      end else if (cur_low_zero) begin
        value_d = ookpd_pkg::BIT_ZERO;
      end
    end
  end

  assign half_d  = CAP_W'((CAP_W + 1)'(cap_q) + (CAP_W + 1)'(1) >> 1);
  assign index_d = ookpd_pkg::INDEX_W'(FRAME_CNT - half_d);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      phase_q     <= 1'b0;
      prev_low_q  <= 1'b0;
      prev_mag_q  <= '0;
      held_low_q  <= 1'b0;
      held_mag_q  <= '0;
      cap_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_axis_tready_o) begin
        in_valid_q <= s_axis_tvalid_i;
      end

      out_valid_q <= out_valid_d;

      if (advance) begin
        phase_q    <= !phase_q;
        prev_mag_q <= us_q;
        prev_low_q <= phase_q;
        if (searching) begin
          if (ref_high_short && cur_low_start) begin
            cap_q <= CAP_FULL;
          end
        end else begin
          cap_q <= cap_q - CAP_W'(1);
          if (!pair_end) begin
            // hold the high half until its low arrives
            held_mag_q <= us_q;
            held_low_q <= phase_q;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      us_q <= us_in;
    end
    if (advance && gives_result) begin
      out_value_q <= value_d;
      out_index_q <= index_d;
      out_last_q  <= (cap_q == CAP_W'(1));
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {out_index_q, out_value_q};
  assign m_axis_tlast_o  = out_last_q;

endmodule

@@ test/ook_pulse_pair_decoder_top_tb.sv @@
// Self-checking bench for ook_pulse_pair_decoder_top: edge counts in, decoded pairs out.
// Carries its own pulse-width predictor and checks every output transaction against it.
// Depends on ookpd_pkg and the decoder RTL.
`timescale 1ns / 1ps

module ook_pulse_pair_decoder_top_tb;

  localparam int unsigned FRAME_BITS   = 64;
  localparam int unsigned DRAIN_CYCLES = 8;
  // no register behind this index
  localparam logic [ookpd_pkg::CFG_IDX_W-1:0] CFG_SPARE = 4'hF;

  typedef struct packed {
    logic [ookpd_pkg::VALUE_W-1:0] value;
    logic [ookpd_pkg::INDEX_W-1:0] index;
    logic                          last;
  } pair_result_t;

  logic                            clk_i = 1'b0;
  logic                            rst_ni = 1'b0;
  logic                            s_axis_tvalid_i = 1'b0;
  logic                            s_axis_tready_o;
  logic [15:0]                     s_axis_tdata_i = '0;
  logic                            m_axis_tvalid_o;
  logic                            m_axis_tready_i = 1'b0;
  logic [7:0]                      m_axis_tdata_o;
  logic                            m_axis_tlast_o;
  logic                            cfg_valid_i = 1'b0;
  logic                            cfg_ready_o;
  logic [ookpd_pkg::CFG_IDX_W-1:0] cfg_index_i = ookpd_pkg::CFG_TOLERANCE;
  logic [ookpd_pkg::CFG_DAT_W-1:0] cfg_data_i = '0;

  // Register copies seen by the predictor
  logic [ookpd_pkg::TOL_W-1:0] window_pct = ookpd_pkg::TOL_RESET;
  logic [ookpd_pkg::NOM_W-1:0] short_nom  = ookpd_pkg::SHORT_RESET;
  logic [ookpd_pkg::NOM_W-1:0] zero_nom   = ookpd_pkg::ZERO_RESET;
  logic [ookpd_pkg::NOM_W-1:0] start_nom  = ookpd_pkg::START_RESET;

  // Decoder state as predicted
  logic        low_next = 1'b0;
  int          last_dur = 0;
  int unsigned edges_left = 0;
  int          pair_high = 0;

  logic [15:0]                  edge_q[$];
  logic [ookpd_pkg::CFG_IDX_W+ookpd_pkg::CFG_DAT_W-1:0] reg_write_q[$];
  pair_result_t                 decoded_pair_q[$];

  int unsigned edges_queued = 0, edges_accepted = 0;
  int unsigned regs_queued = 0, regs_written = 0;
  int unsigned pairs_checked = 0, frames_closed = 0, mismatch_count = 0;
  int unsigned stall_odds = 0;
  int unsigned src_gap = 0, sink_gap = 0;
  logic        gen_low = 1'b0;
  pair_result_t want;

  ook_pulse_pair_decoder_top #(.FRAME_BITS(FRAME_BITS)) uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------- predictor

  function automatic int unsigned sat_us(logic [15:0] ticks);
    int unsigned us;
    us = 32'(ticks) * 10000 / 1875;
    return (us > 32767) ? 32767 : us;
  endfunction

  function automatic void window_of(input int unsigned nominal,
                                    output int unsigned lo, output int unsigned hi);
    int unsigned pct;
    pct = (window_pct > ookpd_pkg::TOL_MAX) ? 99 : window_pct;
    lo = nominal * (100 - pct) / 100;
    hi = nominal * (100 + pct) / 100;
  endfunction

  function automatic bit in_window(int unsigned mag, int unsigned nominal);
    int unsigned lo, hi;
    window_of(nominal, lo, hi);
    return mag > lo && mag < hi;
  endfunction

  function automatic bit high_fits(int dur, int unsigned nominal);
    return dur > 0 && in_window(dur, nominal);
  endfunction

  function automatic bit low_fits(int dur, int unsigned nominal);
    return dur < 0 && in_window(-dur, nominal);
  endfunction

  function automatic void predict_edge(logic [15:0] ticks);
    int          dur, prev;
    int unsigned left;
    pair_result_t res;
    dur = low_next ? -int'(sat_us(ticks)) : int'(sat_us(ticks));
    low_next = ~low_next;
    prev = last_dur;
    last_dur = dur;
    if (edges_left == 0) begin
      // searching: the start edge itself is not captured
      if (high_fits(prev, short_nom) && low_fits(dur, start_nom))
        edges_left = 2 * FRAME_BITS;
      return;
    end
    left = edges_left;
    edges_left = left - 1;
    if (left % 2 == 0) begin
      pair_high = dur;
      return;
    end
    res.value = ookpd_pkg::BIT_INVALID;
    if (high_fits(pair_high, short_nom)) begin
      if (low_fits(dur, short_nom))
        res.value = ookpd_pkg::BIT_ONE;
      else if (low_fits(dur, zero_nom))
        res.value = ookpd_pkg::BIT_ZERO;
    end
    res.index = ookpd_pkg::INDEX_W'(FRAME_BITS - (left + 1) / 2);
    res.last  = (left == 1);
    decoded_pair_q.push_back(res);
  endfunction

  // ---------------------------------------------------------------- edge driver

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid_i <= 1'b0;
      s_axis_tdata_i  <= '0;
      src_gap         <= 0;
      edges_accepted  <= 0;
      low_next   = 1'b0;
      last_dur   = 0;
      edges_left = 0;
      pair_high  = 0;
    end else begin
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        predict_edge(s_axis_tdata_i);
        edges_accepted <= edges_accepted + 1;
      end
      if (!s_axis_tvalid_i || s_axis_tready_o) begin
        if (src_gap != 0) begin
          src_gap         <= src_gap - 1;
          s_axis_tvalid_i <= 1'b0;
        end else if (stall_odds != 0 && $urandom_range(stall_odds - 1, 0) == 0) begin
          src_gap         <= $urandom_range(5, 0);
          s_axis_tvalid_i <= 1'b0;
        end else if (edge_q.size() != 0) begin
          s_axis_tvalid_i <= 1'b1;
          s_axis_tdata_i  <= edge_q.pop_front();
        end else begin
          s_axis_tvalid_i <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------- register writes

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_valid_i  <= 1'b0;
      cfg_index_i  <= ookpd_pkg::CFG_TOLERANCE;
      cfg_data_i   <= '0;
      regs_written <= 0;
      window_pct   <= ookpd_pkg::TOL_RESET;
      short_nom    <= ookpd_pkg::SHORT_RESET;
      zero_nom     <= ookpd_pkg::ZERO_RESET;
      start_nom    <= ookpd_pkg::START_RESET;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        regs_written <= regs_written + 1;
        case (cfg_index_i)
          ookpd_pkg::CFG_TOLERANCE: window_pct <= cfg_data_i[ookpd_pkg::TOL_W-1:0];
          ookpd_pkg::CFG_SHORT:     short_nom  <= cfg_data_i[ookpd_pkg::NOM_W-1:0];
          ookpd_pkg::CFG_ZERO:      zero_nom   <= cfg_data_i[ookpd_pkg::NOM_W-1:0];
          ookpd_pkg::CFG_START:     start_nom  <= cfg_data_i[ookpd_pkg::NOM_W-1:0];
          default: ;
        endcase
      end
      if (!cfg_valid_i || cfg_ready_o) begin
        if (reg_write_q.size() != 0) begin
          cfg_valid_i <= 1'b1;
          {cfg_index_i, cfg_data_i} <= reg_write_q.pop_front();
        end else begin
          cfg_valid_i <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------- result monitor

  task automatic report_mismatch(input string what);
    $display("%0t ns  mismatch: %s", $time, what);
    mismatch_count++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready_i <= 1'b0;
      sink_gap        <= 0;
    end else begin
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        pairs_checked++;
        if (m_axis_tlast_o)
          frames_closed++;
        if (decoded_pair_q.size() == 0) begin
          report_mismatch($sformatf("unexpected pair value %0d index %0d last %0d",
                                    m_axis_tdata_o[1:0], m_axis_tdata_o[7:2], m_axis_tlast_o));
        end else begin
          want = decoded_pair_q.pop_front();
          if (m_axis_tdata_o[1:0] !== want.value)
            report_mismatch($sformatf("bit_value %0d, expected %0d (index %0d)",
                                      m_axis_tdata_o[1:0], want.value, want.index));
          if (m_axis_tdata_o[7:2] !== want.index)
            report_mismatch($sformatf("bit_index %0d, expected %0d",
                                      m_axis_tdata_o[7:2], want.index));
          if (m_axis_tlast_o !== want.last)
            report_mismatch($sformatf("frame_last %0d, expected %0d (index %0d)",
                                      m_axis_tlast_o, want.last, want.index));
        end
      end
      if (sink_gap != 0) begin
        sink_gap        <= sink_gap - 1;
        m_axis_tready_i <= 1'b0;
      end else if (stall_odds != 0 && $urandom_range(stall_odds - 1, 0) == 0) begin
        sink_gap        <= $urandom_range(5, 0);
        m_axis_tready_i <= 1'b0;
      end else begin
        m_axis_tready_i <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------- stimulus

  task automatic queue_edge(input logic [15:0] ticks);
    edge_q.push_back(ticks);
    edges_queued++;
    gen_low = ~gen_low;
  endtask

  // Pick a tick count whose duration falls inside the nominal's current window, else fall back to the nominal
  function automatic logic [15:0] ticks_near(int unsigned nominal);
    int unsigned lo, hi, t_lo, t_hi, ticks;
    window_of(nominal, lo, hi);
    t_lo = lo * 3 / 16;
    t_hi = (hi * 3 / 16 + 1 > 65535) ? 65535 : hi * 3 / 16 + 1;
    for (int k = 0; k < 16; k++) begin
      ticks = $urandom_range(t_hi, t_lo);
      if (in_window(sat_us(ticks), nominal))
        return 16'(ticks);
    end
    return 16'(nominal * 3 / 16);
  endfunction

  task automatic queue_start();
    if (gen_low)
      queue_edge(16'($urandom_range(2000, 0)));
    queue_edge(ticks_near(short_nom));
    queue_edge(ticks_near(start_nom));
  endtask

  task automatic queue_pairs(input int unsigned n);
    int unsigned pick;
    repeat (n) begin
      pick = $urandom_range(19, 0);
      queue_edge(pick < 18 ? ticks_near(short_nom) : 16'($urandom()));
      pick = $urandom_range(9, 0);
      if (pick < 4)
        queue_edge(ticks_near(short_nom));
      else if (pick < 8)
        queue_edge(ticks_near(zero_nom));
      else if (pick == 8)
        queue_edge(ticks_near(start_nom));
      else
        queue_edge(16'($urandom()));
    end
  endtask

  // Random edges with the odd near-miss start pattern mixed in
  task automatic queue_noise(input int unsigned n);
    repeat (n) begin
      case ($urandom_range(5, 0))
        0: begin
          if (gen_low)
            queue_edge(16'($urandom_range(700, 0)));
          queue_edge(ticks_near(short_nom));
          queue_edge(16'($urandom_range(1200, 0)));
        end
        1, 2:    queue_edge(16'($urandom()));
        default: queue_edge(16'($urandom_range(800, 0)));
      endcase
    end
  endtask

  task automatic queue_frame();
    queue_start();
    queue_pairs(FRAME_BITS);
  endtask

  task automatic set_regs(input logic [15:0] pct, input logic [15:0] short_us,
                          input logic [15:0] zero_us, input logic [15:0] start_us);
    reg_write_q.push_back({ookpd_pkg::CFG_TOLERANCE, pct});
    reg_write_q.push_back({ookpd_pkg::CFG_SHORT, short_us});
    reg_write_q.push_back({ookpd_pkg::CFG_ZERO, zero_us});
    reg_write_q.push_back({ookpd_pkg::CFG_START, start_us});
    regs_queued += 4;
  endtask

  // Hold until every edge is in, every write done and every pair out, then let the pipe drain
  task automatic settle();
    do @(posedge clk_i);
    while (edges_accepted != edges_queued || regs_written != regs_queued ||
           decoded_pair_q.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  initial begin
    #5_000_000;
    $display("timeout with %0d pairs still expected", decoded_pair_q.size());
    $display("Some tests failed");
    $finish;
  end

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Reset values: extremes of the count, saturation boundary, then a start
    // and hand-picked pairs on and around the window edges
    stall_odds = 4;
    queue_edge(16'd0);
    queue_edge(16'hFFFF);
    queue_edge(16'd6143);
    queue_edge(16'd6144);
    queue_edge(16'd1);
    queue_edge(16'hFFFF);
    queue_edge(16'd51);
    queue_edge(16'd501);
    queue_edge(16'd51);  queue_edge(16'd51);
    queue_edge(16'd51);  queue_edge(16'd229);
    queue_edge(16'd51);  queue_edge(16'd501);
    queue_edge(16'd0);   queue_edge(16'd51);
    queue_edge(16'd600); queue_edge(16'd51);
    queue_edge(16'd51);  queue_edge(16'd0);
    queue_edge(16'd26);  queue_edge(16'd77);
    queue_edge(16'd25);  queue_edge(16'd51);
    queue_edge(16'd78);  queue_edge(16'd51);
    queue_pairs(FRAME_BITS - 9);
    queue_noise(30);
    settle();

    // Tolerance above 99, widest short nominal, spare bits set in the data
    set_regs(16'hFF7F, 16'hFFFF, 16'd100, 16'd9000);
    settle();
    stall_odds = 8;
    queue_frame();
    queue_noise(20);
    settle();

    // Empty windows: zero tolerance and a zero nominal; a write to no register
    set_regs(16'h0000, 16'hC001, 16'h0000, 16'h8001);
    reg_write_q.push_back({CFG_SPARE, 16'hFFFF});
    regs_queued++;
    settle();
    stall_odds = 3;
    queue_noise(40);
    queue_start();
    queue_pairs(4);
    settle();

    set_regs(16'd10 | 16'($urandom_range(511, 0)) << 7,
             16'd500 | 16'($urandom_range(3, 0)) << 14,
             16'd2000 | 16'($urandom_range(3, 0)) << 14,
             16'd4000 | 16'($urandom_range(3, 0)) << 14);
    settle();
    stall_odds = 0;
    queue_frame();
    queue_noise(20);
    settle();

    set_regs(16'($urandom_range(99, 20)) | 16'($urandom_range(511, 0)) << 7,
             16'($urandom_range(5000, 1)) | 16'($urandom_range(3, 0)) << 14,
             16'($urandom_range(5000, 1)) | 16'($urandom_range(3, 0)) << 14,
             16'($urandom_range(5000, 1)) | 16'($urandom_range(3, 0)) << 14);
    settle();
    stall_odds = 6;
    queue_frame();
    queue_noise(20);
    settle();

    // Back to the default timing, no idling on either side
    set_regs(16'(ookpd_pkg::TOL_RESET), 16'(ookpd_pkg::SHORT_RESET),
             16'(ookpd_pkg::ZERO_RESET), 16'(ookpd_pkg::START_RESET));
    settle();
    stall_odds = 0;
    queue_frame();
    settle();

    $display("Sent %0d edge events across six register settings (%0d register writes).",
             edges_accepted, regs_written);
    $display("Checked %0d decoded pairs, %0d of them closing a frame; %0d mismatches.",
             pairs_checked, frames_closed, mismatch_count);
    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
